// ===== src/brf_pkg.sv =====
package brf_pkg;

   localparam int REG_DEPTH = 31;
   localparam int PSR_DEPTH = 6;

   typedef logic [4:0] reg_addr_type;
   typedef logic [2:0] psr_slot_type;
   typedef logic [4:0] mode_type;

   typedef enum logic [2:0] {
      OP_READ_REG    = 3'd0,
      OP_WRITE_REG   = 3'd1,
      OP_READ_STATUS = 3'd2,
      OP_WRITE_STATUS = 3'd3,
      OP_READ_SAVED  = 3'd4,
      OP_WRITE_SAVED = 3'd5,
      OP_DECODE      = 3'd6,
      OP_IRQ_POLL    = 3'd7
   } opcode_type;

   localparam mode_type MODE_USR = 5'h10;
   localparam mode_type MODE_FIQ = 5'h11;
   localparam mode_type MODE_IRQ = 5'h12;
   localparam mode_type MODE_SVC = 5'h13;
   localparam mode_type MODE_ABT = 5'h17;
   localparam mode_type MODE_UND = 5'h1B;
   localparam mode_type MODE_SYS = 5'h1F;

   localparam int BIT_N = 31;
   localparam int BIT_Z = 30;
   localparam int BIT_C = 29;
   localparam int BIT_V = 28;
   localparam int BIT_I = 7;
   localparam int BIT_T = 5;

   localparam logic [31:0] RESET_STATUS = 32'h0000_00D3;
   localparam logic [31:0] IRQ_VECTOR   = 32'h0000_0018;

   // Bank layout: main r0..r15, FIQ r8..r14, then r13/r14 pairs of SVC, ABT, IRQ, UND
   localparam reg_addr_type PC_ADDR     = 5'd15;
   localparam reg_addr_type FIQ_BASE    = 5'd16;
   localparam reg_addr_type SVC_PAIR    = 5'd23;
   localparam reg_addr_type ABT_PAIR    = 5'd25;
   localparam reg_addr_type IRQ_PAIR    = 5'd27;
   localparam reg_addr_type UND_PAIR    = 5'd29;
   localparam reg_addr_type LR_IRQ_ADDR = 5'd28;

   localparam psr_slot_type SLOT_SHARED = 3'd0;
   localparam psr_slot_type SLOT_FIQ    = 3'd1;
   localparam psr_slot_type SLOT_SVC    = 3'd2;
   localparam psr_slot_type SLOT_ABT    = 3'd3;
   localparam psr_slot_type SLOT_IRQ    = 3'd4;
   localparam psr_slot_type SLOT_UND    = 3'd5;

   typedef struct packed {
      logic         en;
      reg_addr_type addr;
   } reg_rd_type;

   typedef struct packed {
      logic         en;
      reg_addr_type addr;
      logic [31:0]  data;
   } reg_wr_type;

   typedef struct packed {
      logic         en;
      psr_slot_type addr;
   } psr_rd_type;

   typedef struct packed {
      logic         en;
      psr_slot_type addr;
      logic [31:0]  data;
   } psr_wr_type;

   typedef struct packed {
      logic        pass;
      logic [11:0] index;
   } decode_type;

   function automatic logic mode_defined(input mode_type m);
      logic ok;
      unique case (m)
         MODE_USR, MODE_FIQ, MODE_IRQ, MODE_SVC,
         MODE_ABT, MODE_UND, MODE_SYS: ok = 1'b1;
         default: ok = 1'b0;
      endcase
      return ok;
   endfunction

   function automatic psr_slot_type psr_slot(input mode_type m);
      psr_slot_type s;
      unique case (m)
         MODE_FIQ: s = SLOT_FIQ;
         MODE_SVC: s = SLOT_SVC;
         MODE_ABT: s = SLOT_ABT;
         MODE_IRQ: s = SLOT_IRQ;
         MODE_UND: s = SLOT_UND;
         default:  s = SLOT_SHARED;
      endcase
      return s;
   endfunction

   function automatic reg_addr_type reg_addr(input mode_type m, input logic [3:0] r);
      reg_addr_type a;
      reg_addr_type pair;
      logic         banked_pair;
      a           = {1'b0, r};
      pair        = SVC_PAIR;
      banked_pair = 1'b0;
      unique case (m)
         MODE_FIQ: begin
            if (r >= 4'd8 && r != 4'd15) begin
               a = FIQ_BASE + {1'b0, r - 4'd8};
            end
         end
         MODE_SVC: begin
            pair        = SVC_PAIR;
            banked_pair = 1'b1;
         end
         MODE_ABT: begin
            pair        = ABT_PAIR;
            banked_pair = 1'b1;
         end
         MODE_IRQ: begin
            pair        = IRQ_PAIR;
            banked_pair = 1'b1;
         end
         MODE_UND: begin
            pair        = UND_PAIR;
            banked_pair = 1'b1;
         end
         default: ;
      endcase
      if (banked_pair && (r == 4'd13 || r == 4'd14)) begin
         a = pair + {4'd0, r[0] ^ 1'b1};
      end
      return a;
   endfunction

endpackage

// ===== src/brf_reg_mem.sv =====
module brf_reg_mem (
   input  logic                clock,
   input  logic                reset,
   input  brf_pkg::reg_rd_type rd,
   input  brf_pkg::reg_wr_type wr,
   output logic [31:0]         rd_data
);
   import brf_pkg::*;

   logic [31:0]          mem [0:REG_DEPTH-1];
   logic [REG_DEPTH-1:0] valid_ff;
   logic [31:0]          data_ff;
   logic                 hit_ff;

   // entries never written since reset read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr.en) begin
         valid_ff[wr.addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      if (rd.en) begin
         data_ff <= mem[rd.addr];
         hit_ff  <= valid_ff[rd.addr];
      end
   end

   assign rd_data = hit_ff ? data_ff : 32'd0;

endmodule

// ===== src/brf_psr_mem.sv =====
module brf_psr_mem (
   input  logic                clock,
   input  logic                reset,
   input  brf_pkg::psr_rd_type rd,
   input  brf_pkg::psr_wr_type wr,
   output logic [31:0]         rd_data
);
   import brf_pkg::*;

   logic [31:0]          mem [0:PSR_DEPTH-1];
   logic [PSR_DEPTH-1:0] valid_ff;
   logic [31:0]          data_ff;
   logic                 hit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr.en) begin
         valid_ff[wr.addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      if (rd.en) begin
         data_ff <= mem[rd.addr];
         hit_ff  <= valid_ff[rd.addr];
      end
   end

   assign rd_data = hit_ff ? data_ff : 32'd0;

endmodule

// ===== src/brf_decode.sv =====
module brf_decode (
   input  logic [31:0]         status,
   input  logic [31:0]         word,
   output brf_pkg::decode_type dec
);
   import brf_pkg::*;

   logic n, z, c, v;
   logic cond_ok;

   assign n = status[BIT_N];
   assign z = status[BIT_Z];
   assign c = status[BIT_C];
   assign v = status[BIT_V];

   always_comb begin
      unique case (word[31:28])
         4'h0: cond_ok = z;
         4'h1: cond_ok = !z;
         4'h2: cond_ok = c;
         4'h3: cond_ok = !c;
         4'h4: cond_ok = n;
         4'h5: cond_ok = !n;
         4'h6: cond_ok = v;
         4'h7: cond_ok = !v;
         4'h8: cond_ok = c && !z;
         4'h9: cond_ok = !c || z;
         4'hA: cond_ok = (n == v);
         4'hB: cond_ok = (n != v);
         4'hC: cond_ok = !z && (n == v);
         4'hD: cond_ok = z || (n != v);
         4'hE: cond_ok = 1'b1;
         default: cond_ok = 1'b0;
      endcase
   end

   // Thumb words always pass and index on bits 15:6
   always_comb begin
      if (status[BIT_T]) begin
         dec.pass  = 1'b1;
         dec.index = {2'b00, word[15:6]};
      end else begin
         dec.pass  = cond_ok;
         dec.index = {word[27:20], word[7:4]};
      end
   end

endmodule

// ===== src/banked_register_file_irq_entry.sv =====
// A request accepted while idle is registered and executed in ST_EXEC; its result is
// then registered and strobed. No new request is taken while busy; an IRQ poll that
// takes the interrupt holds busy through ST_PC_WRITE, as the register memory has a single write port.
// Reset clears the control state and the memory valid bits; the status word
// returns to 0xD3 (supervisor, interrupts masked). Results cannot be stalled.
module banked_register_file_irq_entry (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_opcode,
   input  logic [3:0]  req_reg_index,
   input  logic [31:0] req_data,
   input  logic [15:0] req_irq_enable,
   input  logic [15:0] req_irq_flags,
   input  logic        req_master_enable,
   output logic        rsp_strobe,
   output logic [31:0] rsp_read_data,
   output logic        rsp_cond_pass,
   output logic [11:0] rsp_table_index,
   output logic        rsp_wake,
   output logic        rsp_irq_taken,
   output logic        rsp_bad_mode
);
   import brf_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_PC_WRITE
   } state_type;

   state_type   state_ff, state_in;
   logic [31:0] status_ff, status_in;

   // request held across the memory read
   opcode_type  op_ff;
   logic [3:0]  index_ff;
   logic [31:0] data_ff;
   logic        pending_ff;
   logic        master_ff;

   logic        strobe_ff;
   logic [31:0] read_data_ff, read_data_in;
   logic        pass_ff, pass_in;
   logic [11:0] table_ff, table_in;
   logic        wake_ff, wake_in;
   logic        taken_ff, taken_in;
   logic        bad_ff, bad_in;

   logic        accept;
   mode_type    mode;
   reg_rd_type  reg_rd;
   reg_wr_type  reg_wr;
   psr_rd_type  psr_rd;
   psr_wr_type  psr_wr;
   logic [31:0] reg_q;
   logic [31:0] psr_q;
   decode_type  dec;

   assign accept = start && !busy;
   assign busy   = (state_ff != ST_IDLE);
   assign mode   = status_ff[4:0];

   // Issue the reads at acceptance: the status word cannot change before the
   // data is used, so the banked address picked here stays correct. Decode and
   // poll read the PC for the advance and for the link value.
   always_comb begin
      reg_rd.en   = accept;
      reg_rd.addr = (opcode_type'(req_opcode) == OP_READ_REG)
                    ? reg_addr(mode, req_reg_index) : PC_ADDR;
      psr_rd.en   = accept;
      psr_rd.addr = psr_slot(mode);
   end

   brf_reg_mem u_reg_mem (
      .clock   (clock),
      .reset   (reset),
      .rd      (reg_rd),
      .wr      (reg_wr),
      .rd_data (reg_q)
   );

   brf_psr_mem u_psr_mem (
      .clock   (clock),
      .reset   (reset),
      .rd      (psr_rd),
      .wr      (psr_wr),
      .rd_data (psr_q)
   );

   brf_decode u_decode (
      .status (status_ff),
      .word   (data_ff),
      .dec    (dec)
   );

   // Execute: modify the read data and write back. IRQ entry writes the IRQ
   // link register here and the PC in the following cycle.
   always_comb begin
      state_in     = state_ff;
      status_in    = status_ff;
      reg_wr       = '0;
      psr_wr       = '0;
      read_data_in = 32'd0;
      pass_in      = 1'b0;
      table_in     = 12'd0;
      wake_in      = 1'b0;
      taken_in     = 1'b0;
      bad_in       = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_IDLE;
            case (op_ff)
               OP_READ_REG: begin
                  read_data_in = reg_q;
               end
               OP_WRITE_REG: begin
                  reg_wr.en   = 1'b1;
                  reg_wr.addr = reg_addr(mode, index_ff);
                  reg_wr.data = data_ff;
               end
               OP_READ_STATUS: begin
                  read_data_in = status_ff;
               end
               OP_WRITE_STATUS: begin
                  status_in = data_ff;
                  bad_in    = !mode_defined(data_ff[4:0]);
               end
               OP_READ_SAVED: begin
                  read_data_in = psr_q;
               end
               OP_WRITE_SAVED: begin
                  psr_wr.en   = 1'b1;
                  psr_wr.addr = psr_slot(mode);
                  psr_wr.data = data_ff;
               end
               OP_DECODE: begin
                  pass_in  = dec.pass;
                  table_in = dec.index;
                  // failed ARM condition: advance the PC past the word
                  if (!dec.pass) begin
                     reg_wr.en   = 1'b1;
                     reg_wr.addr = PC_ADDR;
                     reg_wr.data = reg_q + 32'd4;
                  end
               end
               OP_IRQ_POLL: begin
                  wake_in = !status_ff[BIT_I] && pending_ff;
                  if (wake_in && master_ff) begin
                     taken_in          = 1'b1;
                     psr_wr.en         = 1'b1;
                     psr_wr.addr       = SLOT_IRQ;
                     psr_wr.data       = status_ff;
                     status_in[4:0]    = MODE_IRQ;
                     status_in[BIT_I]  = 1'b1;
                     status_in[BIT_T]  = 1'b0;
                     reg_wr.en         = 1'b1;
                     reg_wr.addr       = LR_IRQ_ADDR;
                     reg_wr.data       = reg_q + (status_ff[BIT_T] ? 32'd2 : 32'd4);
                     state_in          = ST_PC_WRITE;
                  end
               end
               default: ;
            endcase
         end
         ST_PC_WRITE: begin
            reg_wr.en   = 1'b1;
            reg_wr.addr = PC_ADDR;
            reg_wr.data = IRQ_VECTOR;
            state_in    = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state, status word and the result strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         status_ff <= RESET_STATUS;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         status_ff <= status_in;
         strobe_ff <= (state_ff == ST_EXEC);
      end
   end

   // request and result payload
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff      <= opcode_type'(req_opcode);
         index_ff   <= req_reg_index;
         data_ff    <= req_data;
         pending_ff <= |(req_irq_enable & req_irq_flags);
         master_ff  <= req_master_enable;
      end
      if (state_ff == ST_EXEC) begin
         read_data_ff <= read_data_in;
         pass_ff      <= pass_in;
         table_ff     <= table_in;
         wake_ff      <= wake_in;
         taken_ff     <= taken_in;
         bad_ff       <= bad_in;
      end
   end

   assign rsp_strobe      = strobe_ff;
   assign rsp_read_data   = read_data_ff;
   assign rsp_cond_pass   = pass_ff;
   assign rsp_table_index = table_ff;
   assign rsp_wake        = wake_ff;
   assign rsp_irq_taken   = taken_ff;
   assign rsp_bad_mode    = bad_ff;

   // accepted request always enters execute next
   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_EXEC))
      else $error("accepted request did not reach execute");

   // taken interrupt leaves the PC write pending alongside its result
   a_taken_pc: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_irq_taken) |-> (state_ff == ST_PC_WRITE && busy))
      else $error("irq entry without pending PC write");

   // IRQ entry implies wake and leaves IRQ mode with I set
   a_taken_mode: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_irq_taken) |->
         (rsp_wake && status_ff[4:0] == MODE_IRQ && status_ff[BIT_I]))
      else $error("irq entry left wrong status");

   // at most one write per memory cycle target: PC write only after execute
   a_pc_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PC_WRITE) |-> $past(state_ff == ST_EXEC))
      else $error("PC write state entered out of order");

endmodule

// ===== verif/brf_access_checker.sv =====
`timescale 1ns / 1ps

module brf_access_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic [2:0]  req_opcode,
   input  logic [3:0]  req_reg_index,
   input  logic [31:0] req_data,
   input  logic [15:0] req_irq_enable,
   input  logic [15:0] req_irq_flags,
   input  logic        req_master_enable,
   input  logic        rsp_strobe,
   input  logic [31:0] rsp_read_data,
   input  logic        rsp_cond_pass,
   input  logic [11:0] rsp_table_index,
   input  logic        rsp_wake,
   input  logic        rsp_irq_taken,
   input  logic        rsp_bad_mode,
   output int          mismatch_count,
   output int          outstanding
);
   import brf_pkg::*;

   localparam int FIQ_CELLS  = 16;
   localparam int PAIR_CELLS = 23;
   localparam int CELL_COUNT = 31;

   typedef enum logic [3:0] {
      CC_EQ, CC_NE, CC_CS, CC_CC, CC_MI, CC_PL, CC_VS, CC_VC,
      CC_HI, CC_LS, CC_GE, CC_LT, CC_GT, CC_LE, CC_AL, CC_NV
   } cond_code_type;

   typedef struct packed {
      logic [31:0] read_data;
      logic        cond_pass;
      logic [11:0] table_index;
      logic        wake;
      logic        irq_taken;
      logic        bad_mode;
   } outcome_type;

   // main r0..r15, FIQ r8..r14, then r13/r14 of SVC, ABT, IRQ, UND
   logic [31:0] gpr_cells [CELL_COUNT];
   logic [31:0] saved_psr [PSR_DEPTH];
   logic [31:0] cpsr;
   outcome_type due_outcomes [$];

   function automatic void clear_model();
      foreach (gpr_cells[i]) gpr_cells[i] = '0;
      foreach (saved_psr[i]) saved_psr[i] = '0;
      cpsr = RESET_STATUS;
   endfunction

   function automatic logic legal_mode(input mode_type m);
      return m inside {MODE_USR, MODE_FIQ, MODE_IRQ, MODE_SVC, MODE_ABT, MODE_UND, MODE_SYS};
   endfunction

   function automatic int cell_of(input mode_type m, input logic [3:0] r);
      int pair;
      pair = -1;
      case (m)
         MODE_FIQ: begin
            if (r >= 4'd8 && r <= 4'd14) begin
               return FIQ_CELLS + int'(r) - 8;
            end
         end
         MODE_SVC: pair = 0;
         MODE_ABT: pair = 1;
         MODE_IRQ: pair = 2;
         MODE_UND: pair = 3;
         default: ;
      endcase
      if (pair >= 0 && (r == 4'd13 || r == 4'd14)) begin
         return PAIR_CELLS + 2 * pair + int'(r) - 13;
      end
      return int'(r);
   endfunction

   function automatic int slot_of(input mode_type m);
      case (m)
         MODE_FIQ: return int'(SLOT_FIQ);
         MODE_SVC: return int'(SLOT_SVC);
         MODE_ABT: return int'(SLOT_ABT);
         MODE_IRQ: return int'(SLOT_IRQ);
         MODE_UND: return int'(SLOT_UND);
         default:  return int'(SLOT_SHARED);
      endcase
   endfunction

   function automatic logic cond_holds(input cond_code_type cc);
      logic n, z, c, v;
      n = cpsr[BIT_N];
      z = cpsr[BIT_Z];
      c = cpsr[BIT_C];
      v = cpsr[BIT_V];
      case (cc)
         CC_EQ: return z;
         CC_NE: return !z;
         CC_CS: return c;
         CC_CC: return !c;
         CC_MI: return n;
         CC_PL: return !n;
         CC_VS: return v;
         CC_VC: return !v;
         CC_HI: return c && !z;
         CC_LS: return !c || z;
         CC_GE: return n == v;
         CC_LT: return n != v;
         CC_GT: return !z && n == v;
         CC_LE: return z || n != v;
         CC_AL: return 1'b1;
         default: return 1'b0;
      endcase
   endfunction

   // Advance the model by one request and return what the block must answer.
   function automatic outcome_type apply_access(input opcode_type op, input logic [3:0] ri,
                                                input logic [31:0] d, input logic [15:0] ie,
                                                input logic [15:0] fl, input logic me);
      outcome_type o;
      mode_type    m;
      logic [31:0] pc;
      o = '0;
      m = mode_type'(cpsr[4:0]);
      case (op)
         OP_READ_REG:    o.read_data = gpr_cells[cell_of(m, ri)];
         OP_WRITE_REG:   gpr_cells[cell_of(m, ri)] = d;
         OP_READ_STATUS: o.read_data = cpsr;
         OP_WRITE_STATUS: begin
            cpsr       = d;
            o.bad_mode = !legal_mode(mode_type'(d[4:0]));
         end
         OP_READ_SAVED:  o.read_data = saved_psr[slot_of(m)];
         OP_WRITE_SAVED: saved_psr[slot_of(m)] = d;
         OP_DECODE: begin
            if (cpsr[BIT_T]) begin
               o.cond_pass   = 1'b1;
               o.table_index = {2'b00, d[15:6]};
            end else begin
               o.table_index = {d[27:20], d[7:4]};
               if (cond_holds(cond_code_type'(d[31:28]))) begin
                  o.cond_pass = 1'b1;
               end else begin
                  gpr_cells[int'(PC_ADDR)] = gpr_cells[int'(PC_ADDR)] + 32'd4;
               end
            end
         end
         default: begin
            if (!cpsr[BIT_I] && (ie & fl) != 16'd0) begin
               o.wake = 1'b1;
               if (me) begin
                  saved_psr[int'(SLOT_IRQ)] = cpsr;
                  pc = gpr_cells[int'(PC_ADDR)];
                  cpsr[4:0]   = MODE_IRQ;
                  cpsr[BIT_I] = 1'b1;
                  if (cpsr[BIT_T]) begin
                     cpsr[BIT_T] = 1'b0;
                     gpr_cells[cell_of(MODE_IRQ, 4'd14)] = pc + 32'd2;
                  end else begin
                     gpr_cells[cell_of(MODE_IRQ, 4'd14)] = pc + 32'd4;
                  end
                  gpr_cells[int'(PC_ADDR)] = IRQ_VECTOR;
                  o.irq_taken = 1'b1;
               end
            end
         end
      endcase
      return o;
   endfunction

   task automatic report_mismatch(input string field, input logic [31:0] seen,
                                  input logic [31:0] wanted);
      $display("%0t ns: response %s is %h, predicted %h", $time, field, seen, wanted);
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      outcome_type want;
      if (reset) begin
         clear_model();
         due_outcomes.delete();
      end else begin
         if (rsp_strobe) begin
            if (due_outcomes.size() == 0) begin
               report_mismatch("strobe with nothing due, read_data", rsp_read_data, '0);
            end else begin
               want = due_outcomes.pop_front();
               if (rsp_read_data !== want.read_data)
                  report_mismatch("read_data", rsp_read_data, want.read_data);
               if (rsp_cond_pass !== want.cond_pass)
                  report_mismatch("cond_pass", 32'(rsp_cond_pass), 32'(want.cond_pass));
               if (rsp_table_index !== want.table_index)
                  report_mismatch("table_index", 32'(rsp_table_index), 32'(want.table_index));
               if (rsp_wake !== want.wake)
                  report_mismatch("wake", 32'(rsp_wake), 32'(want.wake));
               if (rsp_irq_taken !== want.irq_taken)
                  report_mismatch("irq_taken", 32'(rsp_irq_taken), 32'(want.irq_taken));
               if (rsp_bad_mode !== want.bad_mode)
                  report_mismatch("bad_mode", 32'(rsp_bad_mode), 32'(want.bad_mode));
            end
         end
         if (start && !busy) begin
            due_outcomes.push_back(apply_access(opcode_type'(req_opcode), req_reg_index,
                                                req_data, req_irq_enable, req_irq_flags,
                                                req_master_enable));
         end
      end
      outstanding = due_outcomes.size();
   end

endmodule

// ===== verif/banked_register_file_irq_entry_tb.sv =====
`timescale 1ns / 1ps

module banked_register_file_irq_entry_tb;
   import brf_pkg::*;

   localparam int       REQUEST_COUNT = 500;
   localparam int       QUIET_LIMIT   = 200;
   localparam int       RESET_CYCLES  = 11;
   localparam int       DRAIN_CYCLES  = 6;
   // condition field values for the directed decode requests
   localparam logic [3:0] COND_ALWAYS = 4'hE;
   localparam logic [3:0] COND_NEVER  = 4'hF;
   // a mode code that no ARM mode uses
   localparam mode_type MODE_BOGUS  = 5'h00;

   logic        clock             = 1'b0;
   logic        reset             = 1'b1;
   logic        start             = 1'b0;
   logic        busy;
   logic [2:0]  req_opcode        = '0;
   logic [3:0]  req_reg_index     = '0;
   logic [31:0] req_data          = '0;
   logic [15:0] req_irq_enable    = '0;
   logic [15:0] req_irq_flags     = '0;
   logic        req_master_enable = 1'b0;
   logic        rsp_strobe;
   logic [31:0] rsp_read_data;
   logic        rsp_cond_pass;
   logic [11:0] rsp_table_index;
   logic        rsp_wake;
   logic        rsp_irq_taken;
   logic        rsp_bad_mode;
   int          mismatch_count;
   int          outstanding;
   int          quiet_cycles      = 0;

   mode_type legal_modes [7] = '{MODE_USR, MODE_FIQ, MODE_IRQ, MODE_SVC,
                                 MODE_ABT, MODE_UND, MODE_SYS};
   // sender idle percentage per phase: none, heavy, moderate
   int       idle_pct [3]    = '{0, 59, 36};

   always #4 clock = ~clock;

   banked_register_file_irq_entry u_dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_opcode        (req_opcode),
      .req_reg_index     (req_reg_index),
      .req_data          (req_data),
      .req_irq_enable    (req_irq_enable),
      .req_irq_flags     (req_irq_flags),
      .req_master_enable (req_master_enable),
      .rsp_strobe        (rsp_strobe),
      .rsp_read_data     (rsp_read_data),
      .rsp_cond_pass     (rsp_cond_pass),
      .rsp_table_index   (rsp_table_index),
      .rsp_wake          (rsp_wake),
      .rsp_irq_taken     (rsp_irq_taken),
      .rsp_bad_mode      (rsp_bad_mode)
   );

   brf_access_checker u_scoreboard (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_opcode        (req_opcode),
      .req_reg_index     (req_reg_index),
      .req_data          (req_data),
      .req_irq_enable    (req_irq_enable),
      .req_irq_flags     (req_irq_flags),
      .req_master_enable (req_master_enable),
      .rsp_strobe        (rsp_strobe),
      .rsp_read_data     (rsp_read_data),
      .rsp_cond_pass     (rsp_cond_pass),
      .rsp_table_index   (rsp_table_index),
      .rsp_wake          (rsp_wake),
      .rsp_irq_taken     (rsp_irq_taken),
      .rsp_bad_mode      (rsp_bad_mode),
      .mismatch_count    (mismatch_count),
      .outstanding       (outstanding)
   );

   // Watchdog: count edges at which neither a request nor a response moves.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Status word with F set and the remaining control bits clear.
   function automatic logic [31:0] psr(input logic [3:0] nzcv, input logic mask_irq,
                                       input logic thumb, input mode_type m);
      return {nzcv, 20'd0, mask_irq, 1'b1, thumb, m};
   endfunction

   // Present one request at the falling edge and hold it until the block takes it.
   // Returns at the falling edge after acceptance, with start still high.
   task automatic issue(input opcode_type op, input logic [3:0] ri, input logic [31:0] d,
                        input logic [15:0] ie, input logic [15:0] fl, input logic me);
      start             <= 1'b1;
      req_opcode        <= op;
      req_reg_index     <= ri;
      req_data          <= d;
      req_irq_enable    <= ie;
      req_irq_flags     <= fl;
      req_master_enable <= me;
      @(posedge clock);
      while (busy) @(posedge clock);
      @(negedge clock);
   endtask

   // Drop start for a short random gap, with noise on the idle request fields.
   task automatic hold_off(input int pct);
      if ($urandom_range(99) < pct) begin
         start             <= 1'b0;
         req_opcode        <= 3'($urandom());
         req_reg_index     <= 4'($urandom());
         req_data          <= $urandom();
         req_irq_enable    <= 16'($urandom());
         req_irq_flags     <= 16'($urandom());
         req_master_enable <= 1'($urandom());
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
   endtask

   // Mostly legal modes so the banks get exercised; now and then an undefined one.
   task automatic random_request();
      int          pick;
      logic [31:0] word;
      logic [15:0] en_mask;
      logic [15:0] pend;
      logic [3:0]  ri;
      logic        me;
      pick    = $urandom_range(99);
      word    = $urandom();
      en_mask = 16'($urandom());
      pend    = 16'($urandom());
      ri      = 4'($urandom_range(15));
      me      = 1'($urandom());
      if (pick < 20) begin
         issue(OP_READ_REG, ri, word, en_mask, pend, me);
      end else if (pick < 38) begin
         issue(OP_WRITE_REG, ri, word, en_mask, pend, me);
      end else if (pick < 43) begin
         issue(OP_READ_STATUS, ri, word, en_mask, pend, me);
      end else if (pick < 56) begin
         if ($urandom_range(99) < 88) word[4:0] = legal_modes[$urandom_range(6)];
         issue(OP_WRITE_STATUS, ri, word, en_mask, pend, me);
      end else if (pick < 63) begin
         issue(OP_READ_SAVED, ri, word, en_mask, pend, me);
      end else if (pick < 69) begin
         issue(OP_WRITE_SAVED, ri, word, en_mask, pend, me);
      end else if (pick < 84) begin
         issue(OP_DECODE, ri, word, en_mask, pend, me);
      end else begin
         // keep some polls with no overlap between enables and flags
         if ($urandom_range(99) < 20) pend = ~en_mask;
         issue(OP_IRQ_POLL, ri, word, en_mask, pend, me);
      end
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: reset state, supervisor bank, saved status, extremes of data
      issue(OP_READ_STATUS, 4'd0, 32'h0, 16'h0, 16'h0, 1'b0);
      issue(OP_WRITE_REG, 4'd13, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 1'b1);
      issue(OP_WRITE_REG, 4'd14, 32'h8000_0001, 16'h0, 16'h0, 1'b0);
      issue(OP_READ_REG, 4'd13, 32'h0, 16'h0, 16'h0, 1'b0);
      issue(OP_WRITE_SAVED, 4'd0, 32'hFFFF_FFFF, 16'h0, 16'h0, 1'b0);
      issue(OP_READ_SAVED, 4'd15, 32'h0, 16'h0, 16'h0, 1'b0);
      // condition that never passes bumps the PC; always passes leaves it
      issue(OP_DECODE, 4'd0, {COND_NEVER, 28'hFFF_FFFF}, 16'h0, 16'h0, 1'b0);
      issue(OP_DECODE, 4'd0, {COND_ALWAYS, 28'h0}, 16'h0, 16'h0, 1'b0);
      issue(OP_READ_REG, 4'd15, 32'h0, 16'h0, 16'h0, 1'b0);
      // FIQ bank covers r8..r14
      issue(OP_WRITE_STATUS, 4'd0, psr(4'hF, 1'b1, 1'b0, MODE_FIQ), 16'h0, 16'h0, 1'b0);
      issue(OP_WRITE_REG, 4'd8, 32'h1234_5678, 16'h0, 16'h0, 1'b0);
      issue(OP_WRITE_REG, 4'd14, 32'hCAFE_0000, 16'h0, 16'h0, 1'b0);
      issue(OP_READ_REG, 4'd13, 32'h0, 16'h0, 16'h0, 1'b0);
      // undefined mode: flag raised, user set and shared saved slot in use
      issue(OP_WRITE_STATUS, 4'd0, psr(4'h0, 1'b1, 1'b0, MODE_BOGUS), 16'h0, 16'h0, 1'b0);
      issue(OP_READ_REG, 4'd13, 32'h0, 16'h0, 16'h0, 1'b0);
      issue(OP_WRITE_SAVED, 4'd0, 32'h5A5A_A5A5, 16'h0, 16'h0, 1'b0);
      issue(OP_READ_SAVED, 4'd0, 32'h0, 16'h0, 16'h0, 1'b0);
      // user mode, Thumb, interrupts open
      issue(OP_WRITE_STATUS, 4'd0, psr(4'b0110, 1'b0, 1'b1, MODE_USR), 16'h0, 16'h0, 1'b0);
      issue(OP_READ_SAVED, 4'd0, 32'h0, 16'h0, 16'h0, 1'b0);
      issue(OP_DECODE, 4'd0, 32'hFFFF_FFFF, 16'h0, 16'h0, 1'b0);
      issue(OP_IRQ_POLL, 4'd0, 32'h0, 16'hFFFF, 16'h0000, 1'b1);
      // pending but master enable clear: wake only
      issue(OP_IRQ_POLL, 4'd0, 32'h0, 16'hFFFF, 16'hFFFF, 1'b0);
      // Thumb entry: return address is PC + 2
      issue(OP_IRQ_POLL, 4'd0, 32'h0, 16'h8000, 16'h8000, 1'b1);
      issue(OP_READ_REG, 4'd14, 32'h0, 16'h0, 16'h0, 1'b0);
      issue(OP_READ_SAVED, 4'd0, 32'h0, 16'h0, 16'h0, 1'b0);
      // masked now, so nothing happens
      issue(OP_IRQ_POLL, 4'd0, 32'h0, 16'hFFFF, 16'hFFFF, 1'b1);
      // ARM entry from system mode: return address is PC + 4
      issue(OP_WRITE_STATUS, 4'd0, psr(4'hF, 1'b0, 1'b0, MODE_SYS), 16'h0, 16'h0, 1'b0);
      issue(OP_IRQ_POLL, 4'd0, 32'h0, 16'h0001, 16'h0001, 1'b1);

      // Random: one phase per sender idle rate
      foreach (idle_pct[p]) begin
         repeat (REQUEST_COUNT / 3) begin
            hold_off(idle_pct[p]);
            random_request();
         end
      end

      // Drain: wait for every predicted response, then let the pipe settle
      start <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (mismatch_count == 0 && outstanding == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
